>>> src/kpq_pkg.sv
// kpq_pkg: shared constants, codes and types for the keyed priority queue
// used by kpq_cell and keyed_priority_queue_update_core; no dependencies
`default_nettype none
package kpq_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 8;
  localparam int PRI_BITS   = 32;
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_IGNORED  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_POP_EMPT = 2'd3;

  typedef struct packed {
    logic                       valid;
    logic [KEY_BITS-1:0]        key;
    logic signed [PRI_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic                       do_insert;
    logic                       do_update;
    logic                       do_pop;
    logic [KEY_BITS-1:0]        key;
    logic signed [PRI_BITS-1:0] prio;
  } ctrl_t;

  localparam entry_t ENTRY_ZERO = '{valid: 1'b0, key: '0, prio: '0};

endpackage
`default_nettype wire

>>> src/keyed_priority_queue_update_core.sv
// keyed_priority_queue_update_core: keyed max-priority queue built as a sorted
// chain of kpq_cell slots with a registered result; depends on kpq_pkg, kpq_cell
//
// channel   direction  ports
// in        input      in_valid, in_stall, in_cmd, in_item_key, in_item_priority
// out       output     out_valid, out_stall, out_top_key, out_top_priority,
//                      out_entry_count, out_is_empty, out_status
//
// one transaction per cycle while in_stall is low: every slot compares against
// the command in parallel; the chain shifts at most one place at the accepting edge
// the result is registered and appears the cycle after acceptance
// in_stall is high only while a result waits and out_stall is high
// synchronous active-low reset empties every slot and drops any pending result
`default_nettype none
module keyed_priority_queue_update_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_cmd,
  input  wire logic [kpq_pkg::KEY_BITS-1:0]    in_item_key,
  input  wire logic signed [kpq_pkg::PRI_BITS-1:0] in_item_priority,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [kpq_pkg::KEY_BITS-1:0]         out_top_key,
  output logic signed [kpq_pkg::PRI_BITS-1:0]  out_top_priority,
  output logic [kpq_pkg::CNT_BITS-1:0]         out_entry_count,
  output logic                                 out_is_empty,
  output logic [1:0]                           out_status
);
  import kpq_pkg::*;

  entry_t              cell_d     [CAPACITY];
  entry_t              cell_nxt   [CAPACITY];
  entry_t              prev_d     [CAPACITY];
  entry_t              next_d     [CAPACITY];
  logic [CAPACITY-1:0] ge, match, gt, prev_ge, mb_in, mb_out;

  ctrl_t               ctrl;
  logic                accept, found, better, full, is_push, is_pop;
  logic [1:0]          status;
  logic [CNT_BITS-1:0] count_r, count_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [KEY_BITS-1:0] top_key_r;
  logic signed [PRI_BITS-1:0] top_prio_r;
  logic [CNT_BITS-1:0] cnt_out_r;
  logic                empty_r;
  logic [1:0]          status_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_push = accept && (in_cmd == CMD_PUSH);
  assign is_pop  = accept && (in_cmd == CMD_POP);
  assign found   = |match;
  assign better  = |(match & gt);
  assign full    = (count_r == CNT_BITS'(CAPACITY));

  assign ctrl.key       = in_item_key;
  assign ctrl.prio      = in_item_priority;
  assign ctrl.do_insert = is_push && !found && !full;
  assign ctrl.do_update = is_push && found && better;
  assign ctrl.do_pop    = is_pop && (count_r != '0);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign prev_d[gi]  = ENTRY_ZERO;
        assign prev_ge[gi] = 1'b1;
        assign mb_in[gi]   = 1'b0;
      end else begin : g_body
        assign prev_d[gi]  = cell_d[gi-1];
        assign prev_ge[gi] = ge[gi-1];
        assign mb_in[gi]   = mb_out[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign next_d[gi] = ENTRY_ZERO;
      end else begin : g_mid
        assign next_d[gi] = cell_d[gi+1];
      end

      kpq_cell u_cell (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .prev_d          (prev_d[gi]),
        .next_d          (next_d[gi]),
        .prev_ge         (prev_ge[gi]),
        .match_before_in (mb_in[gi]),
        .d               (cell_d[gi]),
        .d_nxt           (cell_nxt[gi]),
        .ge              (ge[gi]),
        .match           (match[gi]),
        .gt              (gt[gi]),
        .match_before_out(mb_out[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctrl.do_insert) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (ctrl.do_pop) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_comb begin
    status = ST_DONE;
    if (is_push) begin
      if (found && !better) begin
        status = ST_IGNORED;
      end else if (!found && full) begin
        status = ST_FULL;
      end
    end else if (is_pop && (count_r == '0)) begin
      status = ST_POP_EMPT;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_key_r  <= cell_nxt[0].valid ? cell_nxt[0].key : '0;
      top_prio_r <= cell_nxt[0].valid ? cell_nxt[0].prio : '0;
      cnt_out_r  <= count_nxt;
      empty_r    <= (count_nxt == '0);
      status_r   <= status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_top_key      = top_key_r;
  assign out_top_priority = top_prio_r;
  assign out_entry_count  = cnt_out_r;
  assign out_is_empty     = empty_r;
  assign out_status       = status_r;

endmodule
`default_nettype wire

>>> src/kpq_cell.sv
// kpq_cell: one slot of the sorted chain, holds a single entry
// and trades it with its neighbors; depends on kpq_pkg
`default_nettype none
module kpq_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire kpq_pkg::ctrl_t  ctrl,
  input  wire kpq_pkg::entry_t prev_d,
  input  wire kpq_pkg::entry_t next_d,
  input  wire logic           prev_ge,
  input  wire logic           match_before_in,
  output kpq_pkg::entry_t     d,
  output kpq_pkg::entry_t     d_nxt,
  output logic                ge,
  output logic                match,
  output logic                gt,
  output logic                match_before_out
);
  import kpq_pkg::*;

  entry_t d_r;
  logic   place;

  assign d     = d_r;
  assign ge    = d_r.valid && (d_r.prio >= ctrl.prio);
  assign gt    = ctrl.prio > d_r.prio;
  assign match = d_r.valid && (d_r.key == ctrl.key);
  assign match_before_out = match_before_in | match;

  // slots behind the updated entry keep their place
  assign place = ctrl.do_insert || (ctrl.do_update && !match_before_in);

  always_comb begin
    d_nxt = d_r;
    if (ctrl.do_pop) begin
      d_nxt = next_d;
    end else if (place && !ge) begin
      if (prev_ge) begin
        d_nxt.valid = 1'b1;
        d_nxt.key   = ctrl.key;
        d_nxt.prio  = ctrl.prio;
      end else begin
        d_nxt = prev_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= ENTRY_ZERO;
    end else begin
      d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// tb: self-checking testbench for keyed_priority_queue_update_core, a keyed max-priority queue
// holds its own sorted-slot model in a small class; drives random push, pop and query traffic
// depends on kpq_pkg and the core under src
`timescale 1ns / 100ps

module tb;
  import kpq_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic signed [PRI_BITS-1:0] PRI_MAX = {1'b0, {(PRI_BITS-1){1'b1}}};
  localparam logic signed [PRI_BITS-1:0] PRI_MIN = {1'b1, {(PRI_BITS-1){1'b0}}};
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 196;

  typedef struct {
    logic [KEY_BITS-1:0]        key;
    logic signed [PRI_BITS-1:0] prio;
    logic [CNT_BITS-1:0]        count;
    logic                       is_empty;
    logic [1:0]                 status;
  } queue_result_t;

  class queue_tracker;
    logic [KEY_BITS-1:0]        slot_key[CAPACITY];
    logic signed [PRI_BITS-1:0] slot_prio[CAPACITY];
    int                         held;
    queue_result_t              expected_results[$];
    int                         mismatch_count;

    function new();
      held = 0;
      mismatch_count = 0;
      foreach (slot_key[i]) begin
        slot_key[i] = '0;
        slot_prio[i] = '0;
      end
    endfunction

    function void take_out(int idx);
      for (int i = idx; i + 1 < held; i++) begin
        slot_key[i] = slot_key[i+1];
        slot_prio[i] = slot_prio[i+1];
      end
      held--;
      slot_key[held] = '0;
      slot_prio[held] = '0;
    endfunction

    // goes behind every entry with greater or equal priority
    function void place(logic [KEY_BITS-1:0] key, logic signed [PRI_BITS-1:0] prio);
      int pos;
      pos = 0;
      while (pos < held && slot_prio[pos] >= prio) pos++;
      for (int i = held; i > pos; i--) begin
        slot_key[i] = slot_key[i-1];
        slot_prio[i] = slot_prio[i-1];
      end
      slot_key[pos] = key;
      slot_prio[pos] = prio;
      held++;
    endfunction

    function void apply_command(logic [1:0] cmd, logic [KEY_BITS-1:0] key,
                                logic signed [PRI_BITS-1:0] prio);
      int            found;
      logic [1:0]    status;
      queue_result_t res;
      found = -1;
      status = ST_DONE;
      if (cmd == CMD_PUSH) begin
        for (int i = 0; i < held; i++) begin
          if (found < 0 && slot_key[i] == key) found = i;
        end
        if (found >= 0) begin
          if (prio > slot_prio[found]) begin
            take_out(found);
            place(key, prio);
          end else begin
            status = ST_IGNORED;
          end
        end else if (held >= CAPACITY) begin
          status = ST_FULL;
        end else begin
          place(key, prio);
        end
      end else if (cmd == CMD_POP) begin
        if (held == 0) status = ST_POP_EMPT;
        else take_out(0);
      end
      res.key = (held > 0) ? slot_key[0] : '0;
      res.prio = (held > 0) ? slot_prio[0] : '0;
      res.count = CNT_BITS'(held);
      res.is_empty = (held == 0);
      res.status = status;
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [KEY_BITS-1:0] key, logic signed [PRI_BITS-1:0] prio,
                               logic [CNT_BITS-1:0] count, logic is_empty, logic [1:0] status);
      queue_result_t want;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: key %0h prio %0d count %0d empty %0b status %0d",
                   key, prio, count, is_empty, status);
        return;
      end
      want = expected_results.pop_front();
      if (key !== want.key || prio !== want.prio || count !== want.count ||
          is_empty !== want.is_empty || status !== want.status) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch: expected key %0h prio %0d count %0d empty %0b status %0d",
                   want.key, want.prio, want.count, want.is_empty, want.status);
          $display("          actual   key %0h prio %0d count %0d empty %0b status %0d",
                   key, prio, count, is_empty, status);
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_cmd = CMD_QUERY;
  logic [KEY_BITS-1:0]        in_item_key = '0;
  logic signed [PRI_BITS-1:0] in_item_priority = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [KEY_BITS-1:0]        out_top_key;
  logic signed [PRI_BITS-1:0] out_top_priority;
  logic [CNT_BITS-1:0]        out_entry_count;
  logic                       out_is_empty;
  logic [1:0]                 out_status;

  bit steady = 1'b0;
  bit hold_request = 1'b0;
  int cycle_count;

  queue_tracker tracker = new();

  keyed_priority_queue_update_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_item_key      (in_item_key),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_top_key      (out_top_key),
    .out_top_priority (out_top_priority),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tracker.check_result(out_top_key, out_top_priority, out_entry_count,
                             out_is_empty, out_status);
      if (in_valid && !in_stall)
        tracker.apply_command(in_cmd, in_item_key, in_item_priority);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_command(input logic [1:0] cmd, input logic [KEY_BITS-1:0] key,
                              input logic signed [PRI_BITS-1:0] prio);
    int gap;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_item_key <= key;
    in_item_priority <= prio;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input int push_pct);
    int                         r;
    logic [1:0]                 cmd;
    logic [KEY_BITS-1:0]        key;
    logic signed [PRI_BITS-1:0] prio;
    r = $urandom_range(0, 99);
    if (r < push_pct) cmd = CMD_PUSH;
    else if (r < push_pct + (100 - push_pct) * 3 / 4) cmd = CMD_POP;
    else cmd = $urandom_range(0, 1) ? CMD_QUERY : CMD_SPARE;
    // narrow key set so updates and a full queue happen often
    key = ($urandom_range(0, 3) == 0) ? KEY_BITS'($urandom) : KEY_BITS'($urandom_range(0, 23));
    r = $urandom_range(0, 9);
    if (r < 4) prio = $signed(PRI_BITS'($urandom_range(0, 16))) - 8;
    else if (r < 8) prio = $urandom;
    else prio = (r == 8) ? PRI_MAX : PRI_MIN;
    send_command(cmd, key, prio);
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        int n;
        n = pick_gap();
        out_stall <= (n > 0);
        repeat (n > 0 ? n : $urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue cases
    send_command(CMD_QUERY, 8'hFF, PRI_MAX);
    send_command(CMD_SPARE, 8'h00, PRI_MIN);
    send_command(CMD_POP, 8'hA5, -1);
    // extremes and ties while filling
    send_command(CMD_PUSH, 8'h00, PRI_MAX);
    send_command(CMD_PUSH, 8'hFF, PRI_MIN);
    send_command(CMD_PUSH, 8'h55, 0);
    send_command(CMD_PUSH, 8'hAA, 0);
    for (int i = 0; i < 12; i++)
      send_command(CMD_PUSH, KEY_BITS'(16 + i), $signed(PRI_BITS'(i % 3)) - 1);
    // full queue: new key dropped, updates still apply
    send_command(CMD_PUSH, 8'h99, 5);
    send_command(CMD_PUSH, 8'hAA, 0);
    send_command(CMD_PUSH, 8'h55, -1);
    send_command(CMD_PUSH, 8'hAA, 1);
    send_command(CMD_PUSH, 8'hFF, PRI_MAX);
    send_command(CMD_POP, 8'h3C, PRI_MIN);
    send_command(CMD_SPARE, 8'hC3, PRI_MAX);

    for (int phase = 0; phase < PHASES; phase++) begin
      steady = (phase == 3);
      if (phase == 1) hold_request = 1'b1;
      repeat (PHASE_ITEMS) send_random((phase % 2 == 0) ? 75 : 30);
    end
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
